@@ hw/rtl/pte_pkg.sv @@
// Shared types, codes and constant tables for the PNG text chunk extractor.
package pte_pkg;

	typedef enum logic [2:0] {
		PH_SIG  = 3'd0,
		PH_LEN  = 3'd1,
		PH_TYPE = 3'd2,
		PH_DATA = 3'd3,
		PH_CRC  = 3'd4
	} phase_t;

	localparam logic [1:0] ST_VALUE    = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOT_PNG  = 2'd2;
	localparam logic [1:0] ST_NO_DESC  = 2'd3;

	localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
	localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
	localparam logic [3:0]  KEY_LEN   = 4'd11;

	typedef struct packed {
		logic [7:0] value_byte;
		logic [1:0] status;
		logic       last;
	} result_t;

	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h89;
			3'd1: b = 8'h50;
			3'd2: b = 8'h4E;
			3'd3: b = 8'h47;
			3'd4: b = 8'h0D;
			3'd5: b = 8'h0A;
			3'd6: b = 8'h1A;
			default: b = 8'h0A;
		endcase
		return b;
	endfunction

	// "Description"
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:  c = 8'h44;
			4'd1:  c = 8'h65;
			4'd2:  c = 8'h73;
			4'd3:  c = 8'h63;
			4'd4:  c = 8'h72;
			4'd5:  c = 8'h69;
			4'd6:  c = 8'h70;
			4'd7:  c = 8'h74;
			4'd8:  c = 8'h69;
			4'd9:  c = 8'h6F;
			4'd10: c = 8'h6E;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/pte_parser.sv @@
// Chunk walker: parser state registers and the per-byte next-state logic.
module pte_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	input  logic             file_start,
	input  logic             file_end,
	output logic             res_valid,
	output pte_pkg::result_t res
);
	import pte_pkg::*;

	phase_t      phase_q, cur_phase, nxt_phase;
	logic [2:0]  fcount_q, cur_fcount, nxt_fcount;
	logic [31:0] clen_q, cur_clen, nxt_clen;
	logic [31:0] ctype_q, cur_ctype, nxt_ctype;
	logic [31:0] left_q, cur_left, nxt_left;
	logic [3:0]  kidx_q, cur_kidx, nxt_kidx;
	logic        kmatch_q, cur_kmatch, nxt_kmatch;
	logic        inval_q, cur_inval, nxt_inval;
	logic        fin_q, cur_fin, nxt_fin;
	logic [31:0] shifted_len, shifted_type;
	logic        left_zero, lst;

	// A new file restarts the parser before this byte is handled.
	always_comb begin
		if (file_start) begin
			cur_phase  = PH_SIG;
			cur_fcount = '0;
			cur_clen   = '0;
			cur_ctype  = '0;
			cur_left   = '0;
			cur_kidx   = '0;
			cur_kmatch = 1'b1;
			cur_inval  = 1'b0;
			cur_fin    = 1'b0;
		end else begin
			cur_phase  = phase_q;
			cur_fcount = fcount_q;
			cur_clen   = clen_q;
			cur_ctype  = ctype_q;
			cur_left   = left_q;
			cur_kidx   = kidx_q;
			cur_kmatch = kmatch_q;
			cur_inval  = inval_q;
			cur_fin    = fin_q;
		end
	end

	assign shifted_len  = {cur_clen[23:0], data_byte};
	assign shifted_type = {cur_ctype[23:0], data_byte};
	assign left_zero    = (cur_left == 32'd1);

	always_comb begin
		nxt_phase  = cur_phase;
		nxt_fcount = cur_fcount;
		nxt_clen   = cur_clen;
		nxt_ctype  = cur_ctype;
		nxt_left   = cur_left;
		nxt_kidx   = cur_kidx;
		nxt_kmatch = cur_kmatch;
		nxt_inval  = cur_inval;
		nxt_fin    = cur_fin;
		res_valid  = 1'b0;
		res        = '0;
		lst        = 1'b0;
		if (!cur_fin) begin
			case (cur_phase)
				PH_SIG: begin
					if (data_byte != sig_byte(cur_fcount)) begin
						res_valid = 1'b1;
						res       = '{value_byte: 8'd0, status: ST_NOT_PNG, last: 1'b1};
						nxt_fin   = 1'b1;
					end else if (cur_fcount == 3'd7) begin
						nxt_phase  = PH_LEN;
						nxt_fcount = '0;
					end else begin
						nxt_fcount = cur_fcount + 3'd1;
					end
				end
				PH_LEN: begin
					nxt_clen = shifted_len;
					if (cur_fcount == 3'd3) begin
						nxt_phase  = PH_TYPE;
						nxt_fcount = '0;
						nxt_ctype  = '0;
					end else begin
						nxt_fcount = cur_fcount + 3'd1;
					end
				end
				PH_TYPE: begin
					nxt_ctype = shifted_type;
					if (cur_fcount == 3'd3) begin
						nxt_fcount = '0;
						if (shifted_type == TYPE_IDAT) begin
							res_valid = 1'b1;
							res       = '{value_byte: 8'd0, status: ST_NO_DESC, last: 1'b1};
							nxt_fin   = 1'b1;
						end else begin
							nxt_left   = cur_clen;
							nxt_kidx   = '0;
							nxt_kmatch = 1'b1;
							nxt_inval  = 1'b0;
							nxt_phase  = (cur_clen == 32'd0) ? PH_CRC : PH_DATA;
						end
					end else begin
						nxt_fcount = cur_fcount + 3'd1;
					end
				end
				PH_DATA: begin
					nxt_left = cur_left - 32'd1;
					if (cur_ctype == TYPE_TEXT) begin
						if (cur_inval) begin
							lst       = left_zero || file_end;
							res_valid = 1'b1;
							res       = '{value_byte: data_byte, status: ST_VALUE, last: lst};
							nxt_fin   = lst;
						end else if (cur_kmatch) begin
							if (data_byte == 8'd0) begin
								if (cur_kidx == KEY_LEN) begin
									if (left_zero) begin
										res_valid = 1'b1;
										res       = '{value_byte: 8'd0, status: ST_EMPTY,
										              last: 1'b1};
										nxt_fin   = 1'b1;
									end else begin
										nxt_inval = 1'b1;
									end
								end else begin
									nxt_kmatch = 1'b0;
								end
							end else if (cur_kidx < KEY_LEN && data_byte == key_char(cur_kidx)) begin
								nxt_kidx = cur_kidx + 4'd1;
							end else begin
								nxt_kmatch = 1'b0;
							end
						end
					end
					if (!nxt_fin && left_zero) begin
						nxt_phase  = PH_CRC;
						nxt_fcount = '0;
					end
				end
				PH_CRC: begin
					if (cur_fcount == 3'd3) begin
						nxt_phase  = PH_LEN;
						nxt_fcount = '0;
						nxt_clen   = '0;
					end else begin
						nxt_fcount = cur_fcount + 3'd1;
					end
				end
				default: begin
				end
			endcase

			// End of file closes out with a final result.
			if (file_end && !nxt_fin) begin
				if (!res_valid) begin
					res_valid = 1'b1;
					res       = '{value_byte: 8'd0,
					              status: (nxt_phase == PH_SIG) ? ST_NOT_PNG : ST_NO_DESC,
					              last: 1'b1};
				end else begin
					res.last = 1'b1;
				end
				nxt_fin = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIG;
			fcount_q <= '0;
			clen_q   <= '0;
			ctype_q  <= '0;
			left_q   <= '0;
			kidx_q   <= '0;
			kmatch_q <= 1'b1;
			inval_q  <= 1'b0;
			fin_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= nxt_phase;
			fcount_q <= nxt_fcount;
			clen_q   <= nxt_clen;
			ctype_q  <= nxt_ctype;
			left_q   <= nxt_left;
			kidx_q   <= nxt_kidx;
			kmatch_q <= nxt_kmatch;
			inval_q  <= nxt_inval;
			fin_q    <= nxt_fin;
		end
	end

endmodule

@@ hw/rtl/pte_out_stage.sv @@
// Result register that holds one result until the receiver takes it.
module pte_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             res_valid,
	input  pte_pkg::result_t res,
	output logic             advance,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       value_byte,
	output logic [1:0]       status,
	output logic             last
);
	import pte_pkg::*;

	logic    valid_q;
	result_t res_q;

	// The register frees up when empty or when its request is taken.
	assign advance = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid  = valid_q;
	assign value_byte = res_q.value_byte;
	assign status     = res_q.status;
	assign last       = res_q.last;

endmodule

@@ hw/rtl/png_text_chunk_extractor_core.sv @@
// Top level of the PNG tEXt "Description" extractor.
//
// Usage: feed a PNG file one byte per request on the input channel
// (in_valid / in_stall), with file_start on the first byte and file_end on
// the last. The block checks the 8-byte signature, walks the chunks and
// emits the bytes that follow the "Description" keyword of a tEXt chunk on
// the output channel (out_valid / out_stall), one request per byte, with
// last on the final one. Status codes report an empty description, a file
// that is not PNG, or no description before the first IDAT or file end.
// Each input byte gives zero or one result.
//
// A result passes through the input register, then the result register.
// Throughput: one byte per cycle while the receiver does not stall; the
// chunk walker updates its counters in one pass from the input register.
// Reset (arst_n low) empties both registers and puts the walker in the
// signature phase. When the receiver stalls, the result register holds its
// request and the input register holds its byte; in_stall rises only when
// both are occupied. After a final result, bytes are dropped until the next
// file_start.
module png_text_chunk_extractor_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       file_start,
	input  logic       file_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] value_byte,
	output logic [1:0] status,
	output logic       last
);
	import pte_pkg::*;

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       file_start_s1;
	logic       file_end_s1;
	logic       advance;
	logic       step;
	logic       res_valid;
	result_t    res;

	// Hold the input byte while the result register cannot advance.
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_byte_s1  <= data_byte;
			file_start_s1 <= file_start;
			file_end_s1   <= file_end;
		end
	end

	pte_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (data_byte_s1),
		.file_start (file_start_s1),
		.file_end   (file_end_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	pte_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.res_valid  (res_valid),
		.res        (res),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value_byte (value_byte),
		.status     (status),
		.last       (last)
	);

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the PNG tEXt Description extractor core.
module tb_top;
	import pte_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT     = 300;   // cycle at which the receiver starts its long hold-off
	localparam int HOLD_LEN    = 250;
	localparam int CALM_FROM   = 600;   // window with no idling on either side
	localparam int CALM_TO     = 900;
	localparam int IDLE_PCT    = 20;

	localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;
	localparam logic [87:0] DESC_KEY  = "Description";
	localparam logic [31:0] IEND_TAG  = "IEND";

	typedef struct packed {
		logic [7:0] data;
		logic       sof;
		logic       eof;
	} byte_req_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic [7:0] data_byte  = 8'h00;
	logic       file_start = 1'b0;
	logic       file_end   = 1'b0;
	logic       out_stall  = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] value_byte;
	logic [1:0] status;
	logic       last;

	png_text_chunk_extractor_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.file_start (file_start),
		.file_end   (file_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value_byte (value_byte),
		.status     (status),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stimulus and expectations
	byte_req_t  file_bytes[$];     // requests waiting to be offered
	result_t    expected_text[$];  // predicted results, oldest first
	logic [7:0] img[$];            // file under construction
	logic [7:0] body[$];           // chunk data under construction

	int cycle_cnt   = 0;
	int errors      = 0;
	int files_built = 0;
	int bytes_total = 0;
	int bytes_taken = 0;
	int results_ok  = 0;
	int status_seen[4];
	int hold_left   = 0;

	byte_req_t next_req;
	result_t   predicted;
	result_t   oldest;

	// Shadow of the chunk walker
	phase_t      walk_phase;
	logic [3:0]  field_cnt;
	logic [31:0] chunk_len;
	logic [31:0] chunk_kind;
	logic [31:0] data_left;
	logic [3:0]  key_pos;
	logic        key_ok;
	logic        emitting;
	logic        file_done;

	function automatic void clear_walker();
		walk_phase = PH_SIG;
		field_cnt  = 4'd0;
		chunk_len  = 32'd0;
		chunk_kind = 32'd0;
		data_left  = 32'd0;
		key_pos    = 4'd0;
		key_ok     = 1'b1;
		emitting   = 1'b0;
		file_done  = 1'b0;
	endfunction

	// Advance the walker by one accepted byte; return 1 when it yields a result.
	function automatic bit walk_png_byte(input byte_req_t req, output result_t res);
		bit hit;
		bit tail;
		hit = 1'b0;
		res = '0;
		if (req.sof)
			clear_walker();
		if (!file_done) begin
			case (walk_phase)
			PH_SIG: begin
				if (req.data != PNG_MAGIC[8 * (7 - field_cnt[2:0]) +: 8]) begin
					res = {8'h00, ST_NOT_PNG, 1'b1};
					hit = 1'b1;
					file_done = 1'b1;
				end else if (field_cnt >= 4'd7) begin
					walk_phase = PH_LEN;
					field_cnt = 4'd0;
				end else
					field_cnt++;
			end
			PH_LEN: begin
				chunk_len = {chunk_len[23:0], req.data};
				field_cnt++;
				if (field_cnt >= 4'd4) begin
					walk_phase = PH_TYPE;
					field_cnt = 4'd0;
					chunk_kind = 32'd0;
				end
			end
			PH_TYPE: begin
				chunk_kind = {chunk_kind[23:0], req.data};
				field_cnt++;
				if (field_cnt >= 4'd4) begin
					field_cnt = 4'd0;
					if (chunk_kind == TYPE_IDAT) begin
						res = {8'h00, ST_NO_DESC, 1'b1};
						hit = 1'b1;
						file_done = 1'b1;
					end else begin
						data_left = chunk_len;
						key_pos = 4'd0;
						key_ok = 1'b1;
						emitting = 1'b0;
						walk_phase = (data_left == 32'd0) ? PH_CRC : PH_DATA;
					end
				end
			end
			PH_DATA: begin
				data_left--;
				if (chunk_kind == TYPE_TEXT) begin
					if (emitting) begin
						tail = (data_left == 32'd0) || req.eof;
						res = {req.data, ST_VALUE, tail};
						hit = 1'b1;
						if (tail)
							file_done = 1'b1;
					end else if (key_ok) begin
						if (req.data == 8'h00) begin
							if (key_pos == KEY_LEN) begin
								if (data_left == 32'd0) begin
									res = {8'h00, ST_EMPTY, 1'b1};
									hit = 1'b1;
									file_done = 1'b1;
								end else
									emitting = 1'b1;
							end else
								key_ok = 1'b0;
						end else if (key_pos < KEY_LEN &&
								req.data == DESC_KEY[8 * (10 - key_pos) +: 8])
							key_pos++;
						else
							key_ok = 1'b0;
					end
				end
				if (!file_done && data_left == 32'd0) begin
					walk_phase = PH_CRC;
					field_cnt = 4'd0;
				end
			end
			PH_CRC: begin
				field_cnt++;
				if (field_cnt >= 4'd4) begin
					walk_phase = PH_LEN;
					field_cnt = 4'd0;
					chunk_len = 32'd0;
				end
			end
			default: ;
			endcase
			// End of file closes out whatever is open
			if (req.eof && !file_done) begin
				if (!hit) begin
					res = {8'h00, (walk_phase == PH_SIG) ? ST_NOT_PNG : ST_NO_DESC, 1'b1};
					hit = 1'b1;
				end else
					res.last = 1'b1;
				file_done = 1'b1;
			end
		end
		return hit;
	endfunction

	// File building
	task automatic put_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			img = {img, w[8 * i +: 8]};
	endtask

	// bad_at < 0 keeps the signature intact, else corrupt that byte
	task automatic put_signature(input int bad_at);
		for (int i = 0; i < 8; i++)
			img = {img, PNG_MAGIC[8 * (7 - i) +: 8] ^
				((i == bad_at) ? 8'($urandom_range(255, 1)) : 8'h00)};
	endtask

	task automatic put_chunk(input logic [31:0] len, input logic [31:0] kind);
		put_word(len);
		put_word(kind);
		foreach (body[i])
			img = {img, body[i]};
		put_word($urandom);
		body.delete();
	endtask

	// Keyword modes: 0 exact, 1 short prefix (maybe empty), 2 one char too many,
	// 3 one char altered, 4 no zero separator at all
	task automatic put_text_body(input int kw_mode, input int val_len);
		int klen;
		int pos;
		klen = (kw_mode == 1) ? $urandom_range(10) : 11;
		for (int i = 0; i < klen; i++)
			body = {body, DESC_KEY[8 * (10 - i) +: 8]};
		if (kw_mode == 2)
			body = {body, 8'($urandom_range(8'h7A, 8'h61))};
		if (kw_mode == 3) begin
			pos = $urandom_range(10);
			body[pos] = body[pos] ^ 8'($urandom_range(255, 1));
		end
		if (kw_mode != 4)
			body = {body, 8'h00};
		repeat (val_len)
			body = {body, (kw_mode == 4) ? 8'($urandom_range(255, 1)) : 8'($urandom)};
	endtask

	// Queue the file, cut to 'cut' bytes (0 keeps it whole), then trailing junk
	task automatic emit_file(input int cut, input bit mark_end, input int junk);
		int n;
		n = (cut <= 0 || cut > img.size()) ? img.size() : cut;
		for (int i = 0; i < n; i++)
			file_bytes = {file_bytes,
				byte_req_t'({img[i], i == 0, mark_end && i == n - 1})};
		repeat (junk)
			file_bytes = {file_bytes, byte_req_t'({8'($urandom), 1'b0, 1'b0})};
		img.delete();
		files_built++;
	endtask

	task automatic random_file();
		int nch;
		bit huge;
		huge = 1'b0;
		if ($urandom_range(14) == 0) begin
			// plain noise
			repeat ($urandom_range(10, 1))
				img = {img, 8'($urandom)};
		end else begin
			put_signature(($urandom_range(11) == 0) ? $urandom_range(7) : -1);
			nch = $urandom_range(4);
			for (int c = 0; c < nch && !huge; c++) begin
				case ($urandom_range(9))
				0, 1, 2, 3: begin
					put_text_body(($urandom_range(2) == 0) ? $urandom_range(4) : 0,
						$urandom_range(12));
					put_chunk(body.size(), TYPE_TEXT);
				end
				4: begin
					repeat ($urandom_range(6))
						body = {body, 8'($urandom)};
					put_chunk(body.size(), $urandom);
				end
				5: put_chunk(32'd0, IEND_TAG);
				6: begin
					repeat ($urandom_range(3))
						body = {body, 8'($urandom)};
					put_chunk($urandom, TYPE_IDAT);
				end
				7: put_chunk(32'd0, TYPE_TEXT);
				8: begin
					// declared length far beyond the file: end lands in the value
					put_text_body(0, $urandom_range(6, 1));
					put_chunk(32'h8000_0000 | $urandom, TYPE_TEXT);
					huge = 1'b1;
				end
				default: begin
					put_text_body($urandom_range(4, 1), $urandom_range(5));
					put_chunk(body.size(), TYPE_TEXT);
				end
				endcase
			end
		end
		if (huge)
			emit_file(img.size() - 4, 1'b1, 0);
		else
			emit_file(($urandom_range(6) == 0) ? $urandom_range(img.size(), 1) : 0,
				$urandom_range(9) != 0,
				($urandom_range(4) == 0) ? $urandom_range(3, 1) : 0);
	endtask

	function automatic bit idle_now();
		return (cycle_cnt < CALM_FROM || cycle_cnt >= CALM_TO) &&
			$urandom_range(99) < IDLE_PCT;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Sender: predict each accepted request, then offer the next byte or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			data_byte  <= 8'h00;
			file_start <= 1'b0;
			file_end   <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (walk_png_byte(byte_req_t'({data_byte, file_start, file_end}), predicted))
					expected_text = {expected_text, predicted};
				bytes_taken++;
			end
			// Hold a stalled request; otherwise advance
			if (!in_valid || !in_stall) begin
				if (file_bytes.size() != 0 && !idle_now()) begin
					next_req = file_bytes.pop_front();
					in_valid   <= 1'b1;
					data_byte  <= next_req.data;
					file_start <= next_req.sof;
					file_end   <= next_req.eof;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Receiver: check each accepted result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_text.size() == 0) begin
					$error("unexpected result: value_byte %0h status %0d last %0b",
						value_byte, status, last);
					errors++;
				end else begin
					oldest = expected_text.pop_front();
					check_field("value_byte", oldest.value_byte, value_byte);
					check_field("status", 8'(oldest.status), 8'(status));
					check_field("last", 8'(oldest.last), 8'(last));
					status_seen[oldest.status]++;
					results_ok++;
				end
			end
			// One long hold-off lets the core fill up and push back on the sender
			if (cycle_cnt == HOLD_AT) begin
				hold_left <= HOLD_LEN - 1;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else
				out_stall <= idle_now();
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$error("timeout after %0d cycles", CYCLE_LIMIT);
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		clear_walker();
		foreach (status_seen[i])
			status_seen[i] = 0;

		// Directed files
		img = {img, 8'h00};                    // one-byte file, start and end together
		emit_file(0, 1'b1, 0);
		img = {img, 8'hFF};                    // bad first byte, then ignored bytes
		emit_file(0, 1'b0, 2);
		put_signature(-1);                     // file ends inside the signature
		emit_file(3, 1'b1, 0);
		put_signature(-1);                     // IDAT stops the walk, length ignored
		put_chunk(32'hFFFF_FFFF, TYPE_IDAT);
		emit_file(0, 1'b1, 0);
		put_signature(-1);                     // plain description, then IEND
		put_text_body(0, 2);
		put_chunk(body.size(), TYPE_TEXT);
		put_chunk(32'd0, IEND_TAG);
		emit_file(0, 1'b1, 0);
		put_signature(-1);                     // matching keyword with nothing after it
		put_text_body(0, 0);
		put_chunk(body.size(), TYPE_TEXT);
		emit_file(0, 1'b1, 0);
		put_signature(-1);                     // empty tEXt, tEXt without separator
		put_chunk(32'd0, TYPE_TEXT);
		put_text_body(4, 3);
		put_chunk(body.size(), TYPE_TEXT);
		emit_file(0, 1'b1, 0);
		put_signature(-1);                     // value holding zero and all-ones bytes
		put_text_body(0, 0);
		body = {body, 8'h00};
		body = {body, 8'hFF};
		body = {body, 8'h00};
		put_chunk(body.size(), TYPE_TEXT);
		emit_file(0, 1'b1, 0);
		put_signature(-1);                     // end of file in the middle of the value
		put_text_body(0, 4);
		put_chunk(32'h0001_0000, TYPE_TEXT);
		emit_file(img.size() - 4, 1'b1, 0);
		put_signature(-1);                     // dropped by the next file_start
		put_word(32'h0000_0010);
		emit_file(0, 1'b0, 0);
		put_signature(-1);                     // near-miss keywords only
		put_text_body(1, 2);
		put_chunk(body.size(), TYPE_TEXT);
		put_text_body(3, 2);
		put_chunk(body.size(), TYPE_TEXT);
		emit_file(0, 1'b1, 0);

		while (file_bytes.size() < 600)
			random_file();
		bytes_total = file_bytes.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every request taken, every prediction matched, then settle
		while (bytes_taken != bytes_total)
			@(negedge clk);
		while (expected_text.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Covered %0d files in %0d bytes, with a %0d-cycle receiver hold-off.",
			files_built, bytes_taken, HOLD_LEN);
		$display("Checked %0d results: %0d text bytes, %0d empty, %0d not PNG, %0d no description.",
			results_ok, status_seen[ST_VALUE], status_seen[ST_EMPTY],
			status_seen[ST_NOT_PNG], status_seen[ST_NO_DESC]);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
